// File: hw/rtl/stereo_feedback_comb_reverb_core_defines.svh
// Assertion macros shared by the reverb core.
`ifndef STEREO_FEEDBACK_COMB_REVERB_CORE_DEFINES_SVH
`define STEREO_FEEDBACK_COMB_REVERB_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SFCR_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
`define SFCR_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define SFCR_ASSERT_IMPLY(lbl, cond, prop)
`define SFCR_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// File: hw/rtl/sfcr_pkg.sv
// Shared constants and types of the stereo comb reverb core.
`default_nettype none
package sfcr_pkg;
  localparam int DELAY_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 32;
  localparam int LEN_W       = 14;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [LEN_W-1:0] DELAY_LENGTH_RESET = LEN_W'(4800);
  localparam logic             REVERB_ENABLE_RESET = 1'b1;

  localparam logic REG_DELAY_LENGTH  = 1'b0;
  localparam logic REG_REVERB_ENABLE = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0] delay_length;
    logic             reverb_enable;
  } sfcr_cfg_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_hit;
    logic              fwd;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } sfcr_lane_ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/stereo_feedback_comb_reverb_core.sv
// Stereo feedback comb reverb core: top level with control and output merge.
// The core takes one stereo pair per clock unless out_tready stalls it, and registers each
// pair in a stage-1 register and then in the output register. That rate holds for every delay
// length, set by the single read port and single write port of each lane's delay memory,
// with the previous pair's comb value forwarded when both land on the same word. The
// delay memories need no clearing pass after reset: a fill count marks how far the
// position has reached, and words beyond it read as zero, so requests are taken at once.
`default_nettype none
`include "stereo_feedback_comb_reverb_core_defines.svh"
module stereo_feedback_comb_reverb_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // in_tdata: sample_left [31:0], sample_right [63:32]
  input  logic [63:0]                 in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_tdata: front_left [31:0], front_right [63:32], rear_left [95:64],
  // rear_right [127:96]
  output logic [127:0]                out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sfcr_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [sfcr_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [sfcr_pkg::APB_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import sfcr_pkg::*;

  sfcr_cfg_t           cfg;
  sfcr_lane_ctl_t      ctl;
  logic [SAMPLE_W-1:0] y_left;
  logic [SAMPLE_W-1:0] y_right;

  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [CNT_W-1:0]    pos_p1;
  logic [CNT_W-1:0]    len_eff;

  logic                s1_valid_r;
  logic                s1_en_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [63:0]         s1_front_r;
  logic                s1_go;
  logic                accept;

  logic                out_valid_r;
  logic [127:0]        out_data_r;

  sfcr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign s1_go     = s1_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~s1_valid_r | s1_go;
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    if (cfg.delay_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (32'(cfg.delay_length) > 32'(DELAY_DEPTH)) begin
      len_eff = CNT_W'(DELAY_DEPTH);
    end else begin
      len_eff = CNT_W'(cfg.delay_length);
    end
  end

  assign pos_p1 = CNT_W'(pos_r) + CNT_W'(1);

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (accept && cfg.reverb_enable) begin
      pos_nxt  = (pos_p1 >= len_eff) ? '0 : pos_p1[ADDR_W-1:0];
      fill_nxt = (pos_p1 > fill_r) ? pos_p1 : fill_r;
    end
  end

  assign ctl.rd_en   = accept;
  assign ctl.rd_addr = pos_r;
  assign ctl.rd_hit  = CNT_W'(pos_r) < fill_r;
  // The word being written this cycle is the one now read: take the new value directly.
  assign ctl.fwd     = s1_go & s1_en_r & (s1_addr_r == pos_r);
  assign ctl.wr_en   = s1_go & s1_en_r;
  assign ctl.wr_addr = s1_addr_r;

  sfcr_lane u_lane_left (
    .clk  (clk),
    .ctl  (ctl),
    .x_in (in_tdata[31:0]),
    .y    (y_left)
  );

  sfcr_lane u_lane_right (
    .clk  (clk),
    .ctl  (ctl),
    .x_in (in_tdata[63:32]),
    .y    (y_right)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_en_r    <= cfg.reverb_enable;
      s1_addr_r  <= pos_r;
      s1_front_r <= in_tdata;
    end
    if (s1_go) begin
      out_data_r <= {s1_en_r ? y_right : '0, s1_en_r ? y_left : '0, s1_front_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SFCR_ASSERT_IMPLY(a_pos_within_fill, 1'b1, CNT_W'(pos_r) <= fill_r)
  `SFCR_ASSERT_IMPLY(a_fill_bounded, 1'b1, fill_r <= CNT_W'(DELAY_DEPTH))
  `SFCR_ASSERT_IMPLY(a_fwd_needs_write, ctl.fwd, ctl.wr_en)
  `SFCR_ASSERT_NEXT(a_stall_holds_addr, s1_valid_r && !s1_go, $stable(s1_addr_r))
endmodule
`default_nettype wire

// File: hw/rtl/sfcr_cfg.sv
// APB register file holding the delay length and the reverb enable.
`default_nettype none
module sfcr_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfcr_pkg::APB_AW-1:0] paddr,
  input  logic [sfcr_pkg::APB_DW-1:0] pwdata,
  output logic [sfcr_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output sfcr_pkg::sfcr_cfg_t         cfg
);
  import sfcr_pkg::*;

  logic [LEN_W-1:0] len_r;
  logic             en_r;
  logic             wr;
  logic             sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  // Registers sit on word addresses; the byte offset is ignored.
  assign sel    = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= DELAY_LENGTH_RESET;
      en_r  <= REVERB_ENABLE_RESET;
    end else if (wr) begin
      case (sel)
        REG_DELAY_LENGTH:  len_r <= pwdata[LEN_W-1:0];
        REG_REVERB_ENABLE: en_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DELAY_LENGTH:  prdata = APB_DW'(len_r);
      REG_REVERB_ENABLE: prdata = APB_DW'(en_r);
      default:           prdata = '0;
    endcase
  end

  assign cfg.delay_length  = len_r;
  assign cfg.reverb_enable = en_r;
endmodule
`default_nettype wire

// File: hw/rtl/sfcr_lane.sv
// One channel of the comb: delay memory, read forwarding and the halving adder.
`default_nettype none
module sfcr_lane (
  input  logic                          clk,
  input  sfcr_pkg::sfcr_lane_ctl_t      ctl,
  input  logic [sfcr_pkg::SAMPLE_W-1:0] x_in,
  output logic [sfcr_pkg::SAMPLE_W-1:0] y
);
  import sfcr_pkg::*;

  logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic [SAMPLE_W-1:0] mem_q_r;
  logic [SAMPLE_W-1:0] x_r;
  logic [SAMPLE_W-1:0] fwd_data_r;
  logic                fwd_r;
  logic                hit_r;
  logic [SAMPLE_W-1:0] d;

  function automatic logic [SAMPLE_W-1:0] half_trunc(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] t;
    // Adding one to negative values makes the shift round toward zero.
    t = v + SAMPLE_W'(v[SAMPLE_W-1]);
    return $unsigned($signed(t) >>> 1);
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= y;
    end
    if (ctl.rd_en) begin
      mem_q_r    <= mem[ctl.rd_addr];
      x_r        <= x_in;
      fwd_r      <= ctl.fwd;
      fwd_data_r <= y;
      hit_r      <= ctl.rd_hit;
    end
  end

  // Entries at or above the fill count were never written and read as zero.
  assign d = fwd_r ? fwd_data_r : (hit_r ? mem_q_r : '0);
  assign y = half_trunc(x_r) + half_trunc(d);
endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the stereo feedback comb reverb core.
module tb;
  import sfcr_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    sample_t front_left;
    sample_t front_right;
    sample_t rear_left;
    sample_t rear_right;
  } stereo_result_t;

  localparam logic [APB_AW-1:0] ADDR_DELAY_LENGTH  = {REG_DELAY_LENGTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_REVERB_ENABLE = {REG_REVERB_ENABLE, 2'b00};
  localparam int RANDOM_PAIRS    = 1100;
  localparam int FULL_DEPTH_PAIRS = 64;
  localparam int MAX_REPORTED    = 20;
  localparam int SETTLE_CYCLES   = 4;
  localparam sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // in_tdata: sample_left [31:0], sample_right [63:32]
  logic [63:0]         in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  // out_tdata: front_left [31:0], front_right [63:32], rear_left [95:64],
  // rear_right [127:96]
  logic [127:0]        out_tdata;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [APB_AW-1:0]   cfg_paddr;
  logic [APB_DW-1:0]   cfg_pwdata;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  stereo_feedback_comb_reverb_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Echo memories, shared position and register copies of the comb predictor.
  sample_t           left_echo [DELAY_DEPTH];
  sample_t           right_echo [DELAY_DEPTH];
  logic [ADDR_W-1:0] echo_pos;
  logic [LEN_W-1:0]  echo_len_reg;
  logic              reverb_on_reg;

  stereo_result_t   pending_results [$];
  int               errors;
  int               sent_pairs;
  int               checked_results;
  int               register_writes;
  bit               gaps_on;
  bit               stalls_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation timed out with %0d results pending", pending_results.size());
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t pick_sample();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        case ($urandom_range(0, 5))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return 0;
          3: return -1;
          4: return SAMPLE_MIN + 1;
          default: return 1;
        endcase
      end
      1, 2: return sample_t'($urandom_range(0, 64)) - 32;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Halving truncates toward zero, as signed division does.
  function automatic sample_t comb_tap(sample_t x, sample_t stored);
    return x / 2 + stored / 2;
  endfunction

  function automatic stereo_result_t predict_pair(sample_t left, sample_t right);
    stereo_result_t res;
    int             len;
    int             nxt;
    len = (echo_len_reg == 0) ? 1 : int'(echo_len_reg);
    if (len > DELAY_DEPTH) len = DELAY_DEPTH;
    res.front_left  = left;
    res.front_right = right;
    if (reverb_on_reg) begin
      res.rear_left  = comb_tap(left, left_echo[echo_pos]);
      res.rear_right = comb_tap(right, right_echo[echo_pos]);
      left_echo[echo_pos]  = res.rear_left;
      right_echo[echo_pos] = res.rear_right;
      // A position left above a lowered length is used once and then wraps.
      nxt = int'(echo_pos) + 1;
      echo_pos = (nxt >= len) ? '0 : ADDR_W'(nxt);
    end else begin
      res.rear_left  = '0;
      res.rear_right = '0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= MAX_REPORTED)
      $display("mismatch in %s at %0t: got %h, wanted %h", what, $time, got, want);
  endtask

  // Result side: random stalls and a check of every accepted result.
  initial begin
    int             stall_left;
    stereo_result_t want;
    logic [127:0]   got;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata;
        if (pending_results.size() == 0) begin
          report_mismatch("unrequested result", got[63:0], '0);
        end else begin
          want = pending_results.pop_front();
          checked_results++;
          if (got[31:0] !== want.front_left)
            report_mismatch("front_left", 64'(got[31:0]), 64'(want.front_left));
          if (got[63:32] !== want.front_right)
            report_mismatch("front_right", 64'(got[63:32]), 64'(want.front_right));
          if (got[95:64] !== want.rear_left)
            report_mismatch("rear_left", 64'(got[95:64]), 64'(want.rear_left));
          if (got[127:96] !== want.rear_right)
            report_mismatch("rear_right", 64'(got[127:96]), 64'(want.rear_right));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_pair(sample_t left, sample_t right);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_pair(left, right));
    sent_pairs++;
  endtask

  // Holds the input back until every pending result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    register_writes++;
  endtask

  task automatic cfg_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_settings();
    logic [APB_DW-1:0] rd;
    cfg_read(ADDR_DELAY_LENGTH, rd);
    if (rd !== APB_DW'(echo_len_reg))
      report_mismatch("delay_length readback", 64'(rd), 64'(echo_len_reg));
    cfg_read(ADDR_REVERB_ENABLE, rd);
    if (rd !== APB_DW'(reverb_on_reg))
      report_mismatch("reverb_enable readback", 64'(rd), 64'(reverb_on_reg));
  endtask

  task automatic apply_settings(logic [LEN_W-1:0] len, logic enable);
    cfg_write(ADDR_DELAY_LENGTH, APB_DW'(len));
    echo_len_reg = len;
    cfg_write(ADDR_REVERB_ENABLE, APB_DW'(enable));
    reverb_on_reg = enable;
    check_settings();
  endtask

  task automatic test_reset_defaults();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    check_settings();
    send_pair(0, 0);
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(-1, 1);
    send_pair(SAMPLE_MIN + 1, -3);
    send_pair(32'sh5555_5555, 32'shAAAA_AAAA);
    drain();
  endtask

  // Bypass zeroes the rear outputs and must leave memories and position alone.
  task automatic test_bypass();
    apply_settings(3, 1'b1);
    send_pair(SAMPLE_MAX, -7);
    send_pair(SAMPLE_MIN, 11);
    drain();
    apply_settings(3, 1'b0);
    send_pair(pick_sample(), pick_sample());
    send_pair(SAMPLE_MAX, SAMPLE_MIN);
    drain();
    apply_settings(3, 1'b1);
    send_pair(-5, 5);
    send_pair(pick_sample(), pick_sample());
    drain();
  endtask

  // A length of zero acts as one, so every pair feeds back on the same word.
  task automatic test_short_lengths();
    apply_settings(0, 1'b1);
    repeat (3) send_pair(-7, 9);
    drain();
    apply_settings(1, 1'b1);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    send_pair(SAMPLE_MIN, SAMPLE_MAX);
    drain();
  endtask

  task automatic test_length_shrink();
    apply_settings(6, 1'b1);
    repeat (5) send_pair(pick_sample(), pick_sample());
    drain();
    apply_settings(2, 1'b1);
    repeat (3) send_pair(pick_sample(), pick_sample());
    drain();
  endtask

  // An all-ones length saturates to the full depth, so the position keeps counting up
  // through words that were never written; the stream runs back to back.
  task automatic test_full_depth();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    apply_settings('1, 1'b1);
    repeat (FULL_DEPTH_PAIRS) send_pair(sample_t'($urandom()), sample_t'($urandom()));
    drain();
  endtask

  task automatic test_random_stream();
    int               count;
    int               phase_len;
    logic [LEN_W-1:0] len;
    count = 0;
    while (count < RANDOM_PAIRS) begin
      case ($urandom_range(0, 19))
        0:           len = 0;
        1:           len = 1;
        2:           len = 2;
        3:           len = LEN_W'(DELAY_DEPTH);
        4:           len = LEN_W'($urandom_range(DELAY_DEPTH + 1, (1 << LEN_W) - 1));
        5, 6, 7, 8:  len = LEN_W'($urandom_range(1, 8));
        9, 10, 11:   len = LEN_W'($urandom_range(1, 300));
        default:     len = LEN_W'($urandom_range(1, 40));
      endcase
      apply_settings(len, $urandom_range(0, 9) != 0);
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) send_pair(pick_sample(), pick_sample());
      count += phase_len;
      drain();
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    left_echo       = '{default: '0};
    right_echo      = '{default: '0};
    echo_pos        = '0;
    echo_len_reg    = DELAY_LENGTH_RESET;
    reverb_on_reg   = REVERB_ENABLE_RESET;
    errors          = 0;
    sent_pairs      = 0;
    checked_results = 0;
    register_writes = 0;
    gaps_on         = 1'b0;
    stalls_on       = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_bypass();
    test_short_lengths();
    test_length_shrink();
    test_full_depth();
    test_random_stream();
    drain();

    $display("sent %0d stereo pairs, checked %0d results, made %0d register writes",
             sent_pairs, checked_results, register_writes);
    $display("lengths from zero past the depth, bypass, shrink below position, stalls");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sfcr_pkg.sv
hw/rtl/sfcr_cfg.sv
hw/rtl/sfcr_lane.sv
hw/rtl/stereo_feedback_comb_reverb_core.sv
tb/tb.sv
